FILE: src/dpw_pkg.sv
package dpw_pkg;

    localparam int DPW_COORD_W    = 12;
    localparam int DPW_COORD_BITS = 12;
    localparam int DPW_CFG_IDX_W  = 3;
    localparam int DPW_CFG_DATA_W = 21;
    localparam int DPW_QUOT_W     = 23;

    // register indexes of the configuration port
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_QUAT_W  = 3'd0;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_QUAT_X  = 3'd1;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_QUAT_Y  = 3'd2;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_QUAT_Z  = 3'd3;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd4;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd5;
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd6;

    localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;

    // pinhole intrinsics in half-pixel units: 2*cx, 2*cy, and the doubled
    // focal lengths over eight (the 8*d factor absorbs the rest)
    localparam logic signed [13:0] DPW_CENTER2 [2] = '{14'sd651, 14'sd507};
    localparam logic [9:0]         DPW_DIVISOR [2] = '{10'd518, 10'd519};

    // floor(2^32 / divisor): estimate is exact or one short
    localparam logic [DPW_QUOT_W-1:0] DPW_RECIP [2] = '{
        23'((64'd1 << 32) / 64'd518),
        23'((64'd1 << 32) / 64'd519)
    };

    localparam logic signed [33:0] ROT_ONE = 34'sd268435456;

    typedef struct packed {
        logic [15:0] depth_mm;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pix_in;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
    } t_pt_out;

endpackage

FILE: src/depth_pixel_to_world_point.sv
// Depth pixel to world point.
// Input channel: i_in_valid / o_in_ready carry one pixel word (depth, column,
// row, BGR). Output channel: o_out_valid / i_out_ready carry one point word
// (world x/y/z in signed 1/16 mm, saturated to 32 bits, color copied).
// A pixel with zero depth is dropped and yields no output word.
// Pipeline: ten register stages (back-projection multiply, reciprocal
// divide with one correction step, 3x3 rotate, round, offset, saturate);
// an accepted word is presented on o_pt from the last one. Throughput is
// one word per clock while the output keeps taking words.
// Each stage holds only while it is full and the one after it cannot take
// its word, so empty slots close up and input keeps flowing while a
// finished word waits at the output.
// Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data;
// write only while no word is in flight. The rotation matrix is
// rebuilt from the quaternion in two registered steps after each write.
// Reset (synchronous, active low) empties the pipeline and loads the
// identity pose with zero translation.
module depth_pixel_to_world_point
    import dpw_pkg::*;
#(
    parameter int COORD_BITS = DPW_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_pix_in                   i_pix,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_pt_out                   o_pt,
    input  logic                      i_cfg_we,
    input  logic [DPW_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DPW_CFG_DATA_W-1:0] i_cfg_data
);

    localparam int Stages    = 10;
    localparam int CoordUsed = (COORD_BITS < DPW_COORD_W) ? COORD_BITS : DPW_COORD_W;
    localparam logic [DPW_COORD_W-1:0] CoordMask =
        DPW_COORD_W'((64'd1 << CoordUsed) - 64'd1);

    // ---------------- configuration ----------------
    logic signed [15:0] r_quat  [4];   // w, x, y, z
    logic signed [20:0] r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0]  <= QUAT_W_RESET;
            r_quat[1]  <= '0;
            r_quat[2]  <= '0;
            r_quat[3]  <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAT_W:  r_quat[0]  <= i_cfg_data[15:0];
                CFG_QUAT_X:  r_quat[1]  <= i_cfg_data[15:0];
                CFG_QUAT_Y:  r_quat[2]  <= i_cfg_data[15:0];
                CFG_QUAT_Z:  r_quat[3]  <= i_cfg_data[15:0];
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data;
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default:     ;  // index beyond the list: drop the write
            endcase
        end
    end

    // Rotation matrix in Q2.28, rebuilt every clock from the quaternion.
    // Step one: the nine Q1.14 products.
    logic signed [31:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pzw, r_pxz, r_pyw, r_pyz, r_pxw;

    always_ff @(posedge i_clk) begin
        r_pxx <= r_quat[1] * r_quat[1];
        r_pyy <= r_quat[2] * r_quat[2];
        r_pzz <= r_quat[3] * r_quat[3];
        r_pxy <= r_quat[1] * r_quat[2];
        r_pzw <= r_quat[3] * r_quat[0];
        r_pxz <= r_quat[1] * r_quat[3];
        r_pyw <= r_quat[2] * r_quat[0];
        r_pyz <= r_quat[2] * r_quat[3];
        r_pxw <= r_quat[1] * r_quat[0];
    end

    // Step two: the matrix entries (doubled sums, diagonal taken from one).
    logic signed [33:0] r_rot [3][3];

    always_ff @(posedge i_clk) begin
        r_rot[0][0] <= ROT_ONE - ((34'(r_pyy) + 34'(r_pzz)) <<< 1);
        r_rot[0][1] <= (34'(r_pxy) - 34'(r_pzw)) <<< 1;
        r_rot[0][2] <= (34'(r_pxz) + 34'(r_pyw)) <<< 1;
        r_rot[1][0] <= (34'(r_pxy) + 34'(r_pzw)) <<< 1;
        r_rot[1][1] <= ROT_ONE - ((34'(r_pxx) + 34'(r_pzz)) <<< 1);
        r_rot[1][2] <= (34'(r_pyz) - 34'(r_pxw)) <<< 1;
        r_rot[2][0] <= (34'(r_pxz) - 34'(r_pyw)) <<< 1;
        r_rot[2][1] <= (34'(r_pyz) + 34'(r_pxw)) <<< 1;
        r_rot[2][2] <= ROT_ONE - ((34'(r_pxx) + 34'(r_pyy)) <<< 1);
    end

    // ---------------- pipeline control ----------------
    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] w_adv;

    // A stage loads when it is empty or its word moves on.
    always_comb begin
        w_adv[Stages-1] = !r_vld[Stages-1] || i_out_ready;
        for (int k = Stages - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            // drop zero-depth pixels right at the entry
            if (w_adv[0]) r_vld[0] <= i_in_valid && (i_pix.depth_mm != '0);
            for (int k = 1; k < Stages; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // color rides along unchanged
    logic [23:0] r_rgb [Stages];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) r_rgb[0] <= {i_pix.blue, i_pix.green, i_pix.red};
        for (int k = 1; k < Stages; k++) begin
            if (w_adv[k]) r_rgb[k] <= r_rgb[k-1];
        end
    end

    // ---------------- stage 0: offset pixel coordinates ----------------
    logic [DPW_COORD_W-1:0] w_coord [2];
    logic [15:0]            r_d;
    logic signed [13:0]     r_diff [2];    // 2u - 2cx, 2v - 2cy

    assign w_coord[0] = i_pix.col & CoordMask;
    assign w_coord[1] = i_pix.row & CoordMask;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_d <= i_pix.depth_mm;
            for (int l = 0; l < 2; l++) begin
                r_diff[l] <= $signed({1'b0, w_coord[l], 1'b0}) - DPW_CENTER2[l];
            end
        end
    end

    // ---------------- stage 1: scale by eight times depth ----------------
    logic signed [33:0] r_n  [2];
    logic [19:0]        r_zc [1:4];    // z in 1/16 mm, held until stage 5

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_n[l] <= r_diff[l] * $signed({1'b0, r_d, 3'b000});
            end
            r_zc[1] <= {r_d, 4'b0000};
        end
        for (int k = 2; k <= 4; k++) begin
            if (w_adv[k]) r_zc[k] <= r_zc[k-1];
        end
    end

    // ---------------- stage 2: magnitude plus half divisor ----------------
    logic [31:0] r_num2 [2];
    logic        r_neg2 [2];

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_neg2[l] <= r_n[l][33];
                // |n| + 259 with the two's complement folded into the add
                r_num2[l] <= r_n[l][33] ? (~r_n[l][31:0]) + 32'd260
                                        : r_n[l][31:0] + 32'd259;
            end
        end
    end

    // ---------------- stage 3: reciprocal multiply ----------------
    logic [54:0]            w_prod [2];
    logic [DPW_QUOT_W-1:0]  r_qe3  [2];
    logic [31:0]            r_num3 [2];
    logic                   r_neg3 [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_prod[l] = {23'b0, r_num2[l]} * {32'b0, DPW_RECIP[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int l = 0; l < 2; l++) begin
                r_qe3[l]  <= w_prod[l][54:32];
                r_num3[l] <= r_num2[l];
                r_neg3[l] <= r_neg2[l];
            end
        end
    end

    // ---------------- stage 4: back-multiply the estimate ----------------
    logic [31:0]            r_qd4  [2];
    logic [31:0]            r_num4 [2];
    logic [DPW_QUOT_W-1:0]  r_qe4  [2];
    logic                   r_neg4 [2];

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int l = 0; l < 2; l++) begin
                r_qd4[l]  <= 32'(r_qe3[l]) * 32'(DPW_DIVISOR[l]);
                r_num4[l] <= r_num3[l];
                r_qe4[l]  <= r_qe3[l];
                r_neg4[l] <= r_neg3[l];
            end
        end
    end

    // ---------------- stage 5: correct quotient, restore sign ----------------
    logic [31:0]        w_rem [2];
    logic               w_inc [2];
    logic signed [24:0] r_c   [3];     // camera point x, y, z in 1/16 mm

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rem[l] = r_num4[l] - r_qd4[l];
            w_inc[l] = w_rem[l] >= 32'(DPW_DIVISOR[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int l = 0; l < 2; l++) begin
                // -(q + inc) = ~q + 1 - inc
                r_c[l] <= r_neg4[l] ? ~{2'b00, r_qe4[l]} + {24'b0, ~w_inc[l]}
                                    :  {2'b00, r_qe4[l]} + {24'b0,  w_inc[l]};
            end
            r_c[2] <= {5'b00000, r_zc[4]};
        end
    end

    // ---------------- stage 6: rotation products ----------------
    logic signed [58:0] r_p [3][3];

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= r_rot[i][j] * r_c[j];
                end
            end
        end
    end

    // ---------------- stage 7: row sums ----------------
    logic signed [60:0] r_acc [3];

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= 61'(r_p[i][0]) + 61'(r_p[i][1]) + 61'(r_p[i][2]);
            end
        end
    end

    // ---------------- stage 8: round to nearest, ties away from zero ----------------
    logic signed [60:0] w_biased [3];
    logic signed [32:0] r_rnd    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // half minus one for negatives turns the floor shift into
            // rounding away from zero
            w_biased[i] = r_acc[i] + (r_acc[i][60] ? 61'sd134217727 : 61'sd134217728);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            for (int i = 0; i < 3; i++) begin
                r_rnd[i] <= w_biased[i][60:28];
            end
        end
    end

    // ---------------- stage 9: translate and saturate ----------------
    logic signed [33:0] w_wide  [3];
    logic signed [31:0] w_sat   [3];
    logic signed [31:0] r_world [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_wide[i] = 34'(r_rnd[i]) + 34'($signed({r_shift[i], 4'b0000}));
            if (w_wide[i][33:31] == 3'b000 || w_wide[i][33:31] == 3'b111) begin
                w_sat[i] = w_wide[i][31:0];
            end else begin
                w_sat[i] = w_wide[i][33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            for (int i = 0; i < 3; i++) begin
                r_world[i] <= w_sat[i];
            end
        end
    end

    assign o_pt.world_x   = r_world[0];
    assign o_pt.world_y   = r_world[1];
    assign o_pt.world_z   = r_world[2];
    assign o_pt.out_blue  = r_rgb[Stages-1][23:16];
    assign o_pt.out_green = r_rgb[Stages-1][15:8];
    assign o_pt.out_red   = r_rgb[Stages-1][7:0];

`ifndef NO_ASSERTIONS
    a_zero_depth_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_pix.depth_mm == '0) |=> !r_vld[0])
        else $error("zero-depth pixel entered the pipeline");

    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_pix.depth_mm != '0) |=> r_vld[0])
        else $error("accepted pixel lost at the entry stage");

    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5-1] |-> (w_rem[0] < (32'(DPW_DIVISOR[0]) << 1)))
        else $error("x quotient estimate off by more than one");

    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5-1] |-> (w_rem[1] < (32'(DPW_DIVISOR[1]) << 1)))
        else $error("y quotient estimate off by more than one");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled while the pipeline has an empty slot");
`endif

endmodule

FILE: tb/dpw_point_checker.sv
`timescale 1ns / 100ps

module dpw_point_checker
    import dpw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  t_pix_in                   i_pix,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  t_pt_out                   i_pt,
    input  logic                      i_cfg_we,
    input  logic [DPW_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DPW_CFG_DATA_W-1:0] i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    // pinhole intrinsics doubled: 2*cx, 2*cy, and 2*fx/8, 2*fy/8 for the 8*d factor
    localparam longint CX2      = 651;
    localparam longint CY2      = 507;
    localparam longint FX_DIV   = 518;
    localparam longint FY_DIV   = 519;
    localparam longint ROT_UNIT = 64'sd1 << 28;
    localparam int     PRINT_CAP = 200;

    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [20:0] shift_mm [3];

    t_pt_out expected_points [$];
    t_pt_out want;
    int      points_seen;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        points_seen  = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_mismatches < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    function automatic longint div_half_away(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // back-project, rotate by the programmed quaternion, offset, saturate
    function automatic t_pt_out project_pixel(input t_pix_in px);
        longint depth, qw, qx, qy, qz, acc;
        longint cam [3];
        longint rot [3][3];
        logic signed [31:0] world [3];
        t_pt_out pt;
        depth  = longint'(px.depth_mm);
        cam[2] = 16 * depth;
        cam[0] = div_half_away((2 * longint'(px.col) - CX2) * 8 * depth, FX_DIV);
        cam[1] = div_half_away((2 * longint'(px.row) - CY2) * 8 * depth, FY_DIV);
        qw = quat_w;
        qx = quat_x;
        qy = quat_y;
        qz = quat_z;
        rot[0][0] = ROT_UNIT - 2 * (qy * qy + qz * qz);
        rot[0][1] = 2 * (qx * qy - qz * qw);
        rot[0][2] = 2 * (qx * qz + qy * qw);
        rot[1][0] = 2 * (qx * qy + qz * qw);
        rot[1][1] = ROT_UNIT - 2 * (qx * qx + qz * qz);
        rot[1][2] = 2 * (qy * qz - qx * qw);
        rot[2][0] = 2 * (qx * qz - qy * qw);
        rot[2][1] = 2 * (qy * qz + qx * qw);
        rot[2][2] = ROT_UNIT - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++) begin
            acc = rot[i][0] * cam[0] + rot[i][1] * cam[1] + rot[i][2] * cam[2];
            world[i] = clamp32(div_half_away(acc, ROT_UNIT) + 16 * longint'(shift_mm[i]));
        end
        pt.world_x   = world[0];
        pt.world_y   = world[1];
        pt.world_z   = world[2];
        pt.out_blue  = px.blue;
        pt.out_green = px.green;
        pt.out_red   = px.red;
        return pt;
    endfunction

    task automatic compare_point(input t_pt_out exp_pt, input t_pt_out got);
        if (got.world_x !== exp_pt.world_x)
            report_mismatch($sformatf("point %0d world_x got %0d want %0d",
                points_seen, got.world_x, exp_pt.world_x));
        if (got.world_y !== exp_pt.world_y)
            report_mismatch($sformatf("point %0d world_y got %0d want %0d",
                points_seen, got.world_y, exp_pt.world_y));
        if (got.world_z !== exp_pt.world_z)
            report_mismatch($sformatf("point %0d world_z got %0d want %0d",
                points_seen, got.world_z, exp_pt.world_z));
        if (got.out_blue !== exp_pt.out_blue)
            report_mismatch($sformatf("point %0d blue got %0d want %0d",
                points_seen, got.out_blue, exp_pt.out_blue));
        if (got.out_green !== exp_pt.out_green)
            report_mismatch($sformatf("point %0d green got %0d want %0d",
                points_seen, got.out_green, exp_pt.out_green));
        if (got.out_red !== exp_pt.out_red)
            report_mismatch($sformatf("point %0d red got %0d want %0d",
                points_seen, got.out_red, exp_pt.out_red));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quat_w = QUAT_W_RESET;
            quat_x = '0;
            quat_y = '0;
            quat_z = '0;
            for (int i = 0; i < 3; i++)
                shift_mm[i] = '0;
            expected_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("point %0d arrived with none pending",
                        points_seen));
                end else begin
                    want = expected_points.pop_front();
                    compare_point(want, i_pt);
                end
                points_seen++;
            end
            // zero depth carries no measurement and yields no word
            if (i_in_valid && i_in_ready && i_pix.depth_mm != '0)
                expected_points = {expected_points, project_pixel(i_pix)};
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUAT_W:  quat_w = i_cfg_data[15:0];
                    CFG_QUAT_X:  quat_x = i_cfg_data[15:0];
                    CFG_QUAT_Y:  quat_y = i_cfg_data[15:0];
                    CFG_QUAT_Z:  quat_z = i_cfg_data[15:0];
                    CFG_SHIFT_X: shift_mm[0] = i_cfg_data;
                    CFG_SHIFT_Y: shift_mm[1] = i_cfg_data;
                    CFG_SHIFT_Z: shift_mm[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_points.size();
    end

endmodule

FILE: tb/tb_depth_pixel_to_world_point.sv
`timescale 1ns / 100ps

module tb_depth_pixel_to_world_point
    import dpw_pkg::*;
();

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RESET_CYCLES    = 12;
    // ten register stages, plus margin; zero-depth words never enter them
    localparam int DRAIN_CYCLES    = 14;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 106;
    // index past the last register: the block must drop writes to it
    localparam logic [DPW_CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int Q_ONE     = 16384;
    localparam int SHIFT_MAX = 1048575;
    localparam int SHIFT_MIN = -1048576;
    localparam int Q_HALF_RT = 11585;  // cos(45 deg) in Q1.14

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    t_pix_in                   i_pix;
    logic                      o_out_valid;
    logic                      i_out_ready;
    t_pt_out                   o_pt;
    logic                      i_cfg_we;
    logic [DPW_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DPW_CFG_DATA_W-1:0] i_cfg_data;

    int mismatch_count;
    int points_pending;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_left;
    int cycle_count;

    depth_pixel_to_world_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pix       (i_pix),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pt        (o_pt),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    dpw_point_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_pix        (i_pix),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_pt         (o_pt),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (points_pending)
    );

    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Guard the whole run; a hung handshake ends here.
    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_depth_pixel_to_world_point: done, errors");
            $finish;
        end
    end

    // Output side: stall at random, or hold off entirely while hold_left runs
    // down so the pipeline backs up into the input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one pixel word: idle at random first, then hold valid and payload
    // until the block takes the word.
    task automatic send_pixel(input t_pix_in px);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pix      <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, wait for every pending point, then idle for DRAIN_CYCLES.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (points_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [DPW_CFG_IDX_W-1:0] idx,
                             input logic [DPW_CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // Program a pose while idle. Fill the unused upper bits of the quaternion
    // writes with noise, and finish with a write to the spare index.
    task automatic load_pose(input int qw, input int qx, input int qy, input int qz,
                             input int sx, input int sy, input int sz);
        settle();
        write_reg(CFG_QUAT_W,  {5'($urandom), 16'(qw)});
        write_reg(CFG_QUAT_X,  {5'($urandom), 16'(qx)});
        write_reg(CFG_QUAT_Y,  {5'($urandom), 16'(qy)});
        write_reg(CFG_QUAT_Z,  {5'($urandom), 16'(qz)});
        write_reg(CFG_SHIFT_X, 21'(sx));
        write_reg(CFG_SHIFT_Y, 21'(sy));
        write_reg(CFG_SHIFT_Z, 21'(sz));
        write_reg(CFG_IDX_SPARE, 21'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int random_quat();
        return int'($urandom_range(2 * Q_ONE)) - Q_ONE;
    endfunction

    function automatic int random_shift();
        return int'($urandom_range(SHIFT_MAX - SHIFT_MIN)) + SHIFT_MIN;
    endfunction

    // Mostly full-range depth, some near range, and a share of empty pixels.
    function automatic t_pix_in random_pixel();
        t_pix_in px;
        px.depth_mm = ($urandom_range(3) == 0) ? 16'($urandom_range(256, 1))
                                               : 16'($urandom_range(65535, 1));
        if ($urandom_range(9) == 0)
            px.depth_mm = '0;
        px.col   = 12'($urandom);
        px.row   = 12'($urandom);
        px.blue  = 8'($urandom);
        px.green = 8'($urandom);
        px.red   = 8'($urandom);
        return px;
    endfunction

    initial begin
        t_pix_in px;
        int      sent;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_pix          = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_QUAT_W;
        i_cfg_data     = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_left      = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset pose: corners, center, empty pixels.
        send_pixel(t_pix_in'{16'd0,     12'd100,  12'd100,  8'd1,    8'd2,    8'd3});
        send_pixel(t_pix_in'{16'd1,     12'd0,    12'd0,    8'd0,    8'd0,    8'd0});
        send_pixel(t_pix_in'{16'd65535, 12'd0,    12'd0,    8'd255,  8'd255,  8'd255});
        send_pixel(t_pix_in'{16'd65535, 12'd4095, 12'd4095, 8'd0,    8'd255,  8'd0});
        send_pixel(t_pix_in'{16'd65535, 12'd0,    12'd4095, 8'd255,  8'd0,    8'd255});
        send_pixel(t_pix_in'{16'd65535, 12'd4095, 12'd0,    8'd17,   8'd34,   8'd51});
        send_pixel(t_pix_in'{16'd1000,  12'd325,  12'd253,  8'd10,   8'd20,   8'd30});
        send_pixel(t_pix_in'{16'd1000,  12'd326,  12'd254,  8'd40,   8'd50,   8'd60});
        send_pixel(t_pix_in'{16'd0,     12'd4095, 12'd4095, 8'd255,  8'd255,  8'd255});
        send_pixel(t_pix_in'{16'd1,     12'd4095, 12'd0,    8'd128,  8'd64,   8'd32});
        send_pixel(t_pix_in'{16'd1,     12'd0,    12'd4095, 8'd1,    8'd128,  8'd254});
        send_pixel(t_pix_in'{16'd32768, 12'd2048, 12'd2048, 8'hAA,   8'h55,   8'hAA});
        send_pixel(t_pix_in'{16'h5555,  12'hAAA,  12'h555,  8'h55,   8'hAA,   8'h55});
        send_pixel(t_pix_in'{16'hAAAA,  12'h555,  12'hAAA,  8'hAA,   8'h55,   8'hAA});
        send_pixel(t_pix_in'{16'd0,     12'd0,    12'd0,    8'd0,    8'd0,    8'd0});
        send_pixel(t_pix_in'{16'd65535, 12'd325,  12'd253,  8'd7,    8'd8,    8'd9});

        for (int ph = 0; ph < PHASES; ph++) begin
            unique case (ph)
                0: ;  // keep the reset pose
                1: load_pose(Q_HALF_RT, 0, 0, Q_HALF_RT, 1000, -2000, 500);
                2: load_pose(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, SHIFT_MAX, SHIFT_MAX, SHIFT_MAX);
                3: load_pose(Q_ONE, Q_ONE, Q_ONE, Q_ONE, SHIFT_MIN, SHIFT_MIN, SHIFT_MIN);
                4: load_pose(0, Q_ONE, 0, 0, random_shift(), random_shift(), random_shift());
                default: load_pose(random_quat(), random_quat(), random_quat(), random_quat(),
                                   random_shift(), random_shift(), random_shift());
            endcase

            // cycle through: no idling, sender gaps, receiver stalls, both
            unique case (ph % 4)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct   = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_gap_pct   = 30;
                    recv_stall_pct = 30;
                end
            endcase

            // Back-pressure: hold the output off while words keep coming.
            if (ph == 4) begin
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
            end

            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                px = random_pixel();
                send_pixel(px);
                sent++;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_depth_pixel_to_world_point: done, clean");
        else
            $display("tb_depth_pixel_to_world_point: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
src/dpw_pkg.sv
src/depth_pixel_to_world_point.sv
tb/dpw_point_checker.sv
tb/tb_depth_pixel_to_world_point.sv
